// File: design/hsvled_pkg.sv
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared types and constants of the HSV to RGB LED ramp.
// ----------------------------------------------------------------------------
package hsvled_pkg;

    // channel level range
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // input field widths
    localparam int HUE_W = 9;
    localparam int FRAC_W = 9;

    // sector term, signed, one unit is 1/15360
    localparam int TERM_W = 16;
    localparam logic signed [16:0] TERM_UNIT = 17'sd15360;

    // 17*v, 255/(256*256*60) folds into 17/2^18
    localparam int V17_W = 14;
    localparam int PROD_W = 29;
    localparam int PROD_SHIFT = 18;

    // channel count and index
    localparam int NUM_CHAN = 3;
    localparam int CHAN_W = 2;
    localparam logic [CHAN_W-1:0] CHAN_LAST = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic CFG_STEP_SPEED = 1'b0;
    localparam logic CFG_INVERSE = 1'b1;
    localparam logic [LEVEL_W-1:0] STEP_SPEED_RESET = 8'd5;

    // request modes
    localparam logic ACT_DIRECT = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // front sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_PUSH
    } front_state_t;

    // one queued request: mode and three channel targets
    typedef struct packed {
        logic               action;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } target_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [LEVEL_W-1:0] step_speed;
        logic               inverse_output;
    } led_cfg_t;

endpackage

// File: design/hsvled_front.sv
// ----------------------------------------------------------------------------
// hsvled_front
// Accepts a request, finds the hue sector and forms one target per channel
// through a shared multiplier, then pushes the targets into the queue.
// ----------------------------------------------------------------------------
module hsvled_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_action,
    input  logic [hsvled_pkg::HUE_W-1:0]           in_hue,
    input  logic [hsvled_pkg::FRAC_W-1:0]          in_sat,
    input  logic [hsvled_pkg::FRAC_W-1:0]          in_val,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output hsvled_pkg::target_t                    push_item
);

    hsvled_pkg::front_state_t state_reg, state_next;
    logic [hsvled_pkg::CHAN_W-1:0] chan_reg;
    logic action_reg;
    logic [hsvled_pkg::V17_W-1:0] v17_reg;
    logic signed [hsvled_pkg::TERM_W-1:0] x_reg [hsvled_pkg::NUM_CHAN];
    logic [hsvled_pkg::LEVEL_W-1:0] t_reg [hsvled_pkg::NUM_CHAN];

    logic accept;
    logic [3:0] sector;
    logic [hsvled_pkg::HUE_W-1:0] sector_base;
    logic [hsvled_pkg::HUE_W-1:0] rem_full;
    logic [5:0] rem;
    logic [14:0] s_rem;
    logic [14:0] s_sixty;
    logic signed [16:0] xv, xp, xq, xt;
    logic signed [16:0] xr, xg, xb;
    logic signed [hsvled_pkg::TERM_W-1:0] x_cur;
    logic [hsvled_pkg::PROD_W-1:0] prod;
    logic [hsvled_pkg::PROD_W-hsvled_pkg::PROD_SHIFT-1:0] scaled;
    logic [hsvled_pkg::LEVEL_W-1:0] level_now;

    assign accept = in_valid && in_ready;

    // sector as the count of passed 60 degree marks
    always_comb
    begin
        sector = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (in_hue >= 9'(k * 60))
            begin
                sector = sector + 4'd1;
            end
        end
    end

    // start angle of the sector
    always_comb
    begin
        case (sector)
            4'd0:    sector_base = 9'd0;
            4'd1:    sector_base = 9'd60;
            4'd2:    sector_base = 9'd120;
            4'd3:    sector_base = 9'd180;
            4'd4:    sector_base = 9'd240;
            4'd5:    sector_base = 9'd300;
            4'd6:    sector_base = 9'd360;
            4'd7:    sector_base = 9'd420;
            default: sector_base = 9'd480;
        endcase
    end

    assign rem_full = in_hue - sector_base;
    assign rem = rem_full[5:0];

    // p, q, t and v terms in units of 1/15360
    assign s_rem = 15'(in_sat) * 15'(rem);
    assign s_sixty = (15'(in_sat) << 6) - (15'(in_sat) << 2);
    assign xv = hsvled_pkg::TERM_UNIT;
    assign xp = hsvled_pkg::TERM_UNIT - $signed({2'b00, s_sixty});
    assign xq = hsvled_pkg::TERM_UNIT - $signed({2'b00, s_rem});
    assign xt = hsvled_pkg::TERM_UNIT - $signed({2'b00, s_sixty})
              + $signed({2'b00, s_rem});

    // sector to channel mapping, hue past the last sector is black
    always_comb
    begin
        case (sector)
            4'd0:
            begin
                xr = xv; xg = xt; xb = xp;
            end
            4'd1:
            begin
                xr = xq; xg = xv; xb = xp;
            end
            4'd2:
            begin
                xr = xp; xg = xv; xb = xt;
            end
            4'd3:
            begin
                xr = xp; xg = xq; xb = xv;
            end
            4'd4:
            begin
                xr = xt; xg = xp; xb = xv;
            end
            4'd5:
            begin
                xr = xv; xg = xp; xb = xq;
            end
            default:
            begin
                xr = '0; xg = '0; xb = '0;
            end
        endcase
    end

    // shared multiplier: one channel a cycle, floor(17*v*x / 2^18), clamped
    assign x_cur = x_reg[chan_reg];
    assign prod = hsvled_pkg::PROD_W'(v17_reg) * hsvled_pkg::PROD_W'(x_cur[14:0]);
    assign scaled = prod[hsvled_pkg::PROD_W-1:hsvled_pkg::PROD_SHIFT];

    always_comb
    begin
        if (x_cur[hsvled_pkg::TERM_W-1] || (x_cur == '0))
        begin
            level_now = '0;
        end
        else if (scaled > 11'(hsvled_pkg::LEVEL_MAX))
        begin
            level_now = hsvled_pkg::LEVEL_MAX;
        end
        else
        begin
            level_now = scaled[hsvled_pkg::LEVEL_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsvled_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = hsvled_pkg::ST_MUL;
                end
            end
            hsvled_pkg::ST_MUL:
            begin
                if (chan_reg == hsvled_pkg::CHAN_LAST)
                begin
                    state_next = push_ready ? hsvled_pkg::ST_IDLE : hsvled_pkg::ST_PUSH;
                end
            end
            hsvled_pkg::ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = hsvled_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsvled_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        push_valid = 1'b0;
        push_item.action = action_reg;
        push_item.red = t_reg[0];
        push_item.green = t_reg[1];
        push_item.blue = t_reg[2];
        case (state_reg)
            hsvled_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            hsvled_pkg::ST_MUL:
            begin
                push_valid = (chan_reg == hsvled_pkg::CHAN_LAST);
                push_item.blue = level_now;
            end
            hsvled_pkg::ST_PUSH:
            begin
                push_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsvled_pkg::ST_IDLE;
            chan_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                chan_reg <= '0;
            end
            else if ((state_reg == hsvled_pkg::ST_MUL) && (chan_reg != hsvled_pkg::CHAN_LAST))
            begin
                chan_reg <= chan_reg + 2'd1;
            end
        end
    end

    // request and target registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= in_action;
            v17_reg <= (hsvled_pkg::V17_W'(in_val) << 4) + hsvled_pkg::V17_W'(in_val);
            x_reg[0] <= xr[hsvled_pkg::TERM_W-1:0];
            x_reg[1] <= xg[hsvled_pkg::TERM_W-1:0];
            x_reg[2] <= xb[hsvled_pkg::TERM_W-1:0];
        end
        if (state_reg == hsvled_pkg::ST_MUL)
        begin
            t_reg[chan_reg] <= level_now;
        end
    end

    // a push is only offered once all three channels are done
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (chan_reg == hsvled_pkg::CHAN_LAST))
        else $error("front pushed before the last channel");

endmodule

// File: design/hsvled_queue.sv
// ----------------------------------------------------------------------------
// hsvled_queue
// Short queue of channel targets between the front and the back end.
// ----------------------------------------------------------------------------
module hsvled_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  hsvled_pkg::target_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output hsvled_pkg::target_t pop_item
);

    hsvled_pkg::target_t slot_reg [hsvled_pkg::QUEUE_DEPTH];
    logic [hsvled_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hsvled_pkg::QCNT_W-1:0] count_reg;
    logic push_fire, pop_fire;

    assign push_ready = (count_reg != hsvled_pkg::QCNT_W'(hsvled_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign push_fire = push_valid && push_ready;
    assign pop_fire = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == hsvled_pkg::QPTR_W'(hsvled_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == hsvled_pkg::QPTR_W'(hsvled_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // a lone push adds one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    // an entry pushed into an empty queue is what pops next
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && (count_reg == '0)) |=> (pop_item == $past(push_item)))
        else $error("queue head does not match pushed entry");

endmodule

// File: design/hsvled_back.sv
// ----------------------------------------------------------------------------
// hsvled_back
// Keeps the channel levels, applies set or step requests from the queue
// and holds the resulting duties in the output register.
// ----------------------------------------------------------------------------
module hsvled_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hsvled_pkg::led_cfg_t              cfg,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  hsvled_pkg::target_t               pop_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hsvled_pkg::LEVEL_W-1:0]    out_red,
    output logic [hsvled_pkg::LEVEL_W-1:0]    out_green,
    output logic [hsvled_pkg::LEVEL_W-1:0]    out_blue,
    output logic                              out_changed
);

    logic [hsvled_pkg::LEVEL_W-1:0] level_reg [hsvled_pkg::NUM_CHAN];
    logic [hsvled_pkg::LEVEL_W-1:0] level_next [hsvled_pkg::NUM_CHAN];
    logic [hsvled_pkg::LEVEL_W-1:0] target [hsvled_pkg::NUM_CHAN];
    logic [hsvled_pkg::LEVEL_W-1:0] duty [hsvled_pkg::NUM_CHAN];
    logic out_valid_reg;
    logic [hsvled_pkg::LEVEL_W-1:0] duty_reg [hsvled_pkg::NUM_CHAN];
    logic changed_reg;
    logic changed_next;
    logic pop_fire;
    logic differs;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop_fire = pop_valid && pop_ready;

    assign target[0] = pop_item.red;
    assign target[1] = pop_item.green;
    assign target[2] = pop_item.blue;
    assign differs = (level_reg[0] != target[0]) || (level_reg[1] != target[1])
                   || (level_reg[2] != target[2]);

    // new levels: direct set, or one saturating step toward the target
    always_comb
    begin
        logic [hsvled_pkg::LEVEL_W:0] up;
        for (int c = 0; c < hsvled_pkg::NUM_CHAN; c++)
        begin
            up = {1'b0, level_reg[c]} + {1'b0, cfg.step_speed};
            if (pop_item.action == hsvled_pkg::ACT_DIRECT)
            begin
                level_next[c] = target[c];
            end
            else if (!differs)
            begin
                level_next[c] = level_reg[c];
            end
            else if (level_reg[c] < target[c])
            begin
                level_next[c] = up[hsvled_pkg::LEVEL_W] ? hsvled_pkg::LEVEL_MAX
                              : up[hsvled_pkg::LEVEL_W-1:0];
            end
            else if (level_reg[c] > target[c])
            begin
                level_next[c] = (level_reg[c] > cfg.step_speed)
                              ? level_reg[c] - cfg.step_speed : '0;
            end
            else
            begin
                level_next[c] = level_reg[c];
            end
            duty[c] = cfg.inverse_output ? (hsvled_pkg::LEVEL_MAX - level_next[c])
                    : level_next[c];
        end
    end

    assign changed_next = (pop_item.action == hsvled_pkg::ACT_DIRECT) || differs;

    // levels and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < hsvled_pkg::NUM_CHAN; c++)
            begin
                level_reg[c] <= '0;
            end
        end
        else
        begin
            if (pop_fire)
            begin
                out_valid_reg <= 1'b1;
                for (int c = 0; c < hsvled_pkg::NUM_CHAN; c++)
                begin
                    level_reg[c] <= level_next[c];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            for (int c = 0; c < hsvled_pkg::NUM_CHAN; c++)
            begin
                duty_reg[c] <= duty[c];
            end
            changed_reg <= changed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red = duty_reg[0];
    assign out_green = duty_reg[1];
    assign out_blue = duty_reg[2];
    assign out_changed = changed_reg;

    // a direct set always reports a change
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && (pop_item.action == hsvled_pkg::ACT_DIRECT)) |=> changed_reg)
        else $error("direct set not flagged as changed");

    // a step with no change leaves the levels alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && !changed_next) |=> $stable(level_reg[0]) && $stable(level_reg[1])
            && $stable(level_reg[2]))
        else $error("levels moved without a reported change");

endmodule

// File: design/hsv_to_rgb_led_ramp.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_ramp
// HSV to RGB LED driver with direct set and stepped transition.
// ----------------------------------------------------------------------------
// A request carries a hue in degrees and a saturation and value where 256 is
// 1.0; the result gives the three PWM duties after the channel levels are
// set (tuser 0) or stepped by step_speed toward the color (tuser 1), plus
// a changed flag. The front accepts a request, forms the sector terms and,
// busy until it pushes, does one channel per cycle on one shared multiplier.
// A two-entry queue and an output register let the back end (one request per
// cycle unless stalled) and the front stall independently. The user writes
// configuration only while no request is in flight, unenforced by the block.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_ramp
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[8:0], saturation[17:9], brightness_value[26:18]
    input  logic        s_tuser,   // action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_duty[7:0], green_duty[15:8], blue_duty[23:16]
    output logic        m_tuser    // changed
);

    logic [hsvled_pkg::LEVEL_W-1:0] step_speed_reg;
    logic inverse_reg;
    hsvled_pkg::led_cfg_t cfg;

    logic push_valid, push_ready;
    hsvled_pkg::target_t push_item;
    logic pop_valid, pop_ready;
    hsvled_pkg::target_t pop_item;
    logic [hsvled_pkg::LEVEL_W-1:0] red, green, blue;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_speed_reg <= hsvled_pkg::STEP_SPEED_RESET;
            inverse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsvled_pkg::CFG_STEP_SPEED: step_speed_reg <= cfg_data;
                hsvled_pkg::CFG_INVERSE:    inverse_reg <= cfg_data[0];
                default:                    inverse_reg <= inverse_reg;
            endcase
        end
    end

    assign cfg.step_speed = step_speed_reg;
    assign cfg.inverse_output = inverse_reg;

    // sector terms and channel targets
    hsvled_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_hue     (s_tdata[8:0]),
        .in_sat     (s_tdata[17:9]),
        .in_val     (s_tdata[26:18]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    hsvled_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // level update and output register
    hsvled_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_red     (red),
        .out_green   (green),
        .out_blue    (blue),
        .out_changed (m_tuser)
    );

    assign m_tdata = {blue, green, red};

endmodule
